FILE: hw/rtl/tfn_pkg.sv
// Shared widths, payload structs and defaults for the triangle face normal unit.
// No dependencies; every other file of the block refers to this package.
package tfn_pkg;

  localparam int COORD_W = 20;
  localparam int EDGE_W = 21;
  localparam int PROD_W = 42;
  localparam int CROSS_W = 43;
  localparam int MAG_W = 42;
  localparam int HALF_W = 21;
  localparam int SQ_W = 84;
  localparam int SUM_W = 86;
  localparam int ROOT_W = 43;
  localparam int REM_W = 45;
  localparam int MINLEN_W = 44;
  localparam int IDX_W = 32;
  localparam int OUT_W = 16;
  localparam int SQRT_STAGES = 43;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam logic [MINLEN_W-1:0] MIN_LENGTH_RESET = 44'd1;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    idx_t idx;
  } tri_t;

  // One cross product component as sign and magnitude.
  typedef struct packed {
    logic sign;
    logic [MAG_W-1:0] mag;
  } comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    idx_t idx;
  } tag_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic degen;
    idx_t idx;
  } result_t;

endpackage

FILE: hw/rtl/tfn_ifs.sv
// Valid/ready channel interfaces for triangles in and normals out.
// Depends on tfn_pkg for field widths.
interface tfn_tri_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::COORD_W-1:0] vert_a_x;
  logic signed [tfn_pkg::COORD_W-1:0] vert_a_y;
  logic signed [tfn_pkg::COORD_W-1:0] vert_a_z;
  logic signed [tfn_pkg::COORD_W-1:0] vert_b_x;
  logic signed [tfn_pkg::COORD_W-1:0] vert_b_y;
  logic signed [tfn_pkg::COORD_W-1:0] vert_b_z;
  logic signed [tfn_pkg::COORD_W-1:0] vert_c_x;
  logic signed [tfn_pkg::COORD_W-1:0] vert_c_y;
  logic signed [tfn_pkg::COORD_W-1:0] vert_c_z;
  logic [tfn_pkg::IDX_W-1:0] vert_a_index;
  logic [tfn_pkg::IDX_W-1:0] vert_b_index;
  logic [tfn_pkg::IDX_W-1:0] vert_c_index;
  modport source(output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                 vert_c_x, vert_c_y, vert_c_z, vert_a_index, vert_b_index, vert_c_index,
                 input ready);
  modport sink(input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
               vert_c_x, vert_c_y, vert_c_z, vert_a_index, vert_b_index, vert_c_index,
               output ready);
endinterface

interface tfn_nrm_if;
  logic valid;
  logic ready;
  logic signed [tfn_pkg::OUT_W-1:0] normal_x;
  logic signed [tfn_pkg::OUT_W-1:0] normal_y;
  logic signed [tfn_pkg::OUT_W-1:0] normal_z;
  logic degenerate;
  logic [tfn_pkg::IDX_W-1:0] out_vert_a_index;
  logic [tfn_pkg::IDX_W-1:0] out_vert_b_index;
  logic [tfn_pkg::IDX_W-1:0] out_vert_c_index;
  modport source(output valid, normal_x, normal_y, normal_z, degenerate, out_vert_a_index,
                 out_vert_b_index, out_vert_c_index, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, degenerate, out_vert_a_index,
               out_vert_b_index, out_vert_c_index, output ready);
endinterface

FILE: hw/rtl/tfn_cross.sv
// Edge, cross product and sum-of-squares pipeline, seven register stages.
// Depends on tfn_pkg.
module tfn_cross (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  tfn_pkg::tri_t tri_in,
  output logic out_valid,
  output logic [tfn_pkg::SUM_W-1:0] sum,
  output tfn_pkg::tag_t tag
);
  localparam int EW = tfn_pkg::EDGE_W;
  localparam int PW = tfn_pkg::PROD_W;
  localparam int CW = tfn_pkg::CROSS_W;
  localparam int MW = tfn_pkg::MAG_W;
  localparam int HW = tfn_pkg::HALF_W;
  localparam int QW = tfn_pkg::SQ_W;
  localparam int SW = tfn_pkg::SUM_W;

  logic [6:0] v;

  logic signed [EW-1:0] e0x, e0y, e0z, e1x, e1y, e1z;
  tfn_pkg::idx_t idx1, idx2, idx3;
  logic signed [PW-1:0] pxa, pxb, pya, pyb, pza, pzb;
  logic signed [CW-1:0] nx, ny, nz;
  tfn_pkg::tag_t tag4, tag5, tag6;
  logic [PW-1:0] hh [3];
  logic [PW-1:0] hl [3];
  logic [PW-1:0] ll [3];
  logic [QW-1:0] sq [3];
  logic [MW-1:0] mags [3];

  assign mags[0] = tag4.x.mag;
  assign mags[1] = tag4.y.mag;
  assign mags[2] = tag4.z.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0x <= EW'(tri_in.bx) - EW'(tri_in.ax);
      e0y <= EW'(tri_in.by) - EW'(tri_in.ay);
      e0z <= EW'(tri_in.bz) - EW'(tri_in.az);
      e1x <= EW'(tri_in.cx) - EW'(tri_in.ax);
      e1y <= EW'(tri_in.cy) - EW'(tri_in.ay);
      e1z <= EW'(tri_in.cz) - EW'(tri_in.az);
      idx1 <= tri_in.idx;

      pxa <= e0y * e1z;
      pxb <= e0z * e1y;
      pya <= e0z * e1x;
      pyb <= e0x * e1z;
      pza <= e0x * e1y;
      pzb <= e0y * e1x;
      idx2 <= idx1;

      nx <= CW'(pxa) - CW'(pxb);
      ny <= CW'(pya) - CW'(pyb);
      nz <= CW'(pza) - CW'(pzb);
      idx3 <= idx2;

      tag4.x.sign <= nx[CW-1];
      tag4.x.mag <= MW'(nx[CW-1] ? -nx : nx);
      tag4.y.sign <= ny[CW-1];
      tag4.y.mag <= MW'(ny[CW-1] ? -ny : ny);
      tag4.z.sign <= nz[CW-1];
      tag4.z.mag <= MW'(nz[CW-1] ? -nz : nz);
      tag4.idx <= idx3;

      // Squares are built from three 21 by 21 partial products.
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mags[i][MW-1:HW] * mags[i][MW-1:HW];
        hl[i] <= mags[i][MW-1:HW] * mags[i][HW-1:0];
        ll[i] <= mags[i][HW-1:0] * mags[i][HW-1:0];
      end
      tag5 <= tag4;

      for (int i = 0; i < 3; i++) begin
        sq[i] <= (QW'(hh[i]) << (2 * HW)) + (QW'(hl[i]) << (HW + 1)) + QW'(ll[i]);
      end
      tag6 <= tag5;

      sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      tag <= tag6;
    end
  end

  assign out_valid = v[6];
endmodule

FILE: hw/rtl/tfn_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on tfn_pkg.
module tfn_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [tfn_pkg::SUM_W-1:0] radicand,
  input  tfn_pkg::tag_t in_tag,
  output logic out_valid,
  output logic [tfn_pkg::ROOT_W-1:0] root,
  output tfn_pkg::tag_t out_tag
);
  localparam int N = tfn_pkg::SQRT_STAGES;
  localparam int SW = tfn_pkg::SUM_W;
  localparam int RW = tfn_pkg::REM_W;
  localparam int QW = tfn_pkg::ROOT_W;

  logic [N-1:0] v;
  logic [SW-1:0] rad [N];
  logic [RW-1:0] rem [N];
  logic [QW-1:0] rt [N];
  tfn_pkg::tag_t tg [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [SW-1:0] rad_in;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] rt_in;
    tfn_pkg::tag_t tg_in;
    logic v_in;
    logic [RW+1:0] rem_sh, trial;
    logic ge;

    if (k == 0) begin : g_first
      assign rad_in = radicand;
      assign rem_in = '0;
      assign rt_in = '0;
      assign tg_in = in_tag;
      assign v_in = in_valid;
    end else begin : g_rest
      assign rad_in = rad[k-1];
      assign rem_in = rem[k-1];
      assign rt_in = rt[k-1];
      assign tg_in = tg[k-1];
      assign v_in = v[k-1];
    end

    assign rem_sh = {rem_in, rad_in[SW-1 -: 2]};
    assign trial = (RW + 2)'({rt_in, 2'b01});
    assign ge = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k] <= rad_in << 2;
        rem[k] <= RW'(ge ? rem_sh - trial : rem_sh);
        rt[k] <= {rt_in[QW-2:0], ge};
        tg[k] <= tg_in;
      end
    end
  end

  assign out_valid = v[N-1];
  assign root = rt[N-1];
  assign out_tag = tg[N-1];
endmodule

FILE: hw/rtl/tfn_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Depends on tfn_pkg.
module tfn_div #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [tfn_pkg::ROOT_W-1:0] den,
  input  logic in_degen,
  input  tfn_pkg::tag_t in_tag,
  output logic out_valid,
  output logic [NORMAL_FRAC_BITS:0] quo [3],
  output logic out_degen,
  output tfn_pkg::tag_t out_tag
);
  localparam int NS = NORMAL_FRAC_BITS + 1;
  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int DW = tfn_pkg::ROOT_W;
  localparam int RW = tfn_pkg::ROOT_W + 1;

  logic [NS-1:0] v;
  logic [DW-1:0] dn [NS];
  logic dg [NS];
  tfn_pkg::tag_t tg [NS];
  logic [RW-1:0] r [NS][3];
  logic [QW-1:0] q [NS][3];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] dn_in;
    logic dg_in;
    tfn_pkg::tag_t tg_in;
    logic v_in;
    logic [RW-1:0] rs [3];
    logic [QW-1:0] q_in [3];
    logic ge [3];

    if (k == 0) begin : g_first
      assign dn_in = den;
      assign dg_in = in_degen;
      assign tg_in = in_tag;
      assign v_in = in_valid;
      assign rs[0] = RW'(in_tag.x.mag);
      assign rs[1] = RW'(in_tag.y.mag);
      assign rs[2] = RW'(in_tag.z.mag);
      for (genvar l = 0; l < 3; l++) begin : g_q
        assign q_in[l] = '0;
      end
    end else begin : g_rest
      assign dn_in = dn[k-1];
      assign dg_in = dg[k-1];
      assign tg_in = tg[k-1];
      assign v_in = v[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_r
        assign rs[l] = {r[k-1][l][RW-2:0], 1'b0};
        assign q_in[l] = q[k-1][l];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign ge[l] = rs[l] >= RW'(dn_in);
      always_ff @(posedge clk) begin
        if (en) begin
          r[k][l] <= ge[l] ? rs[l] - RW'(dn_in) : rs[l];
          q[k][l] <= QW'({q_in[l], ge[l]});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn[k] <= dn_in;
        dg[k] <= dg_in;
        tg[k] <= tg_in;
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_degen = dg[NS-1];
  assign out_tag = tg[NS-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo[l] = q[NS-1][l];
  end
endmodule

FILE: hw/rtl/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: cross product, square root,
// divide and the output register pair. Depends on tfn_pkg, tfn_ifs and the tfn modules.
//
//   channel    role    handshake     payload
//   triangle   sink    valid/ready   three Q12.8 vertices, three indices
//   normal     source  valid/ready   Q1.14 unit normal, degenerate flag, indices
//   cfg        write   cfg_we        min_length (44 bits)
//
// One triangle is taken in every cycle while the skid register is empty; the pipeline
// computes the 43 root bits and the NORMAL_FRAC_BITS + 1 quotient bits (14 fraction
// bits by default), one per stage.
// Reset (synchronous, active high) clears all valid bits and sets min_length to 1.
// Stalls freeze every stage at once; a skid register behind the output register
// takes the item in flight, so triangle.ready comes straight from a flip-flop.
module triangle_face_normal_unit #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tfn_pkg::MINLEN_W-1:0] cfg_wdata,
  tfn_tri_if.sink triangle,
  tfn_nrm_if.source normal
);
  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int OW = tfn_pkg::OUT_W;
  // Quotients are widened to at least the output width before the sign is applied.
  localparam int XW = (QW > OW) ? QW : OW;
  localparam logic [XW-1:0] UP_VALUE = XW'(1) << NORMAL_FRAC_BITS;

  logic [tfn_pkg::MINLEN_W-1:0] min_length;
  logic en;

  tfn_pkg::tri_t tri_in;
  logic c_valid;
  logic [tfn_pkg::SUM_W-1:0] c_sum;
  tfn_pkg::tag_t c_tag;

  logic s_valid;
  logic [tfn_pkg::ROOT_W-1:0] s_root;
  tfn_pkg::tag_t s_tag;

  // Length check stage between the root and the dividers.
  logic l_valid;
  logic [tfn_pkg::ROOT_W-1:0] l_len;
  logic l_degen;
  tfn_pkg::tag_t l_tag;

  logic d_valid;
  logic [QW-1:0] d_quo [3];
  logic d_degen;
  tfn_pkg::tag_t d_tag;

  tfn_pkg::result_t res;
  tfn_pkg::result_t out_data, skid_data;
  logic out_valid, skid_valid;
  logic [XW-1:0] q_ext [3];
  logic [XW-1:0] q_signed [3];
  logic comp_sign [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= tfn_pkg::MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      min_length <= cfg_wdata;
    end
  end

  // The whole pipeline moves together whenever the skid register is empty.
  assign en = !skid_valid;
  assign triangle.ready = en;

  assign tri_in.ax = triangle.vert_a_x;
  assign tri_in.ay = triangle.vert_a_y;
  assign tri_in.az = triangle.vert_a_z;
  assign tri_in.bx = triangle.vert_b_x;
  assign tri_in.by = triangle.vert_b_y;
  assign tri_in.bz = triangle.vert_b_z;
  assign tri_in.cx = triangle.vert_c_x;
  assign tri_in.cy = triangle.vert_c_y;
  assign tri_in.cz = triangle.vert_c_z;
  assign tri_in.idx.a = triangle.vert_a_index;
  assign tri_in.idx.b = triangle.vert_b_index;
  assign tri_in.idx.c = triangle.vert_c_index;

  tfn_cross u_cross (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(triangle.valid), .tri_in(tri_in),
    .out_valid(c_valid), .sum(c_sum), .tag(c_tag)
  );

  tfn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .radicand(c_sum), .in_tag(c_tag),
    .out_valid(s_valid), .root(s_root), .out_tag(s_tag)
  );

  // A zero length is degenerate even when min_length is programmed to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (en) begin
      l_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_len <= s_root;
      l_degen <= (s_root == '0) || (tfn_pkg::MINLEN_W'(s_root) < min_length);
      l_tag <= s_tag;
    end
  end

  tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(l_valid), .den(l_len), .in_degen(l_degen), .in_tag(l_tag),
    .out_valid(d_valid), .quo(d_quo), .out_degen(d_degen), .out_tag(d_tag)
  );

  // Apply the component signs; the result keeps the low 16 bits, so wide
  // fraction settings wrap just like the output field does.
  assign comp_sign[0] = d_tag.x.sign;
  assign comp_sign[1] = d_tag.y.sign;
  assign comp_sign[2] = d_tag.z.sign;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = XW'(d_quo[i]);
      q_signed[i] = comp_sign[i] ? -q_ext[i] : q_ext[i];
    end
    res.idx = d_tag.idx;
    res.degen = d_degen;
    if (d_degen) begin
      res.nx = '0;
      res.ny = $signed(UP_VALUE[OW-1:0]);
      res.nz = '0;
    end else begin
      res.nx = $signed(q_signed[0][OW-1:0]);
      res.ny = $signed(q_signed[1][OW-1:0]);
      res.nz = $signed(q_signed[2][OW-1:0]);
    end
  end

  // Output register plus skid register. A result goes to the output register
  // when it is free or being taken, and otherwise parks in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (normal.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (d_valid) begin
      if (out_valid && !normal.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (normal.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (normal.ready) begin
        out_data <= skid_data;
      end
    end else if (d_valid) begin
      if (out_valid && !normal.ready) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign normal.valid = out_valid;
  assign normal.normal_x = out_data.nx;
  assign normal.normal_y = out_data.ny;
  assign normal.normal_z = out_data.nz;
  assign normal.degenerate = out_data.degen;
  assign normal.out_vert_a_index = out_data.idx.a;
  assign normal.out_vert_b_index = out_data.idx.b;
  assign normal.out_vert_c_index = out_data.idx.c;

  // The skid register only fills behind a stalled output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  // A degenerate result always carries the fallback up vector.
  a_degen_up: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degen) |->
      (out_data.nx == '0 && out_data.nz == '0 && out_data.ny == $signed(UP_VALUE[OW-1:0])))
    else $error("degenerate result without the up vector");

  // While the pipeline is frozen the valid bit of its last stage must not change.
  a_frozen_tail: assert property (@(posedge clk) disable iff (rst)
    (!en && !$past(rst)) |=> ($stable(d_valid) || $past(en)))
    else $error("divider output moved during a stall");
endmodule

FILE: verif/tfn_normal_checker.sv
// Scoreboard for the triangle face normal unit: watches both channels and the
// min_length write port, predicts each normal and compares it with the output.
// Depends on tfn_pkg and the channel interfaces in tfn_ifs.
`timescale 1ns / 1ps

module tfn_normal_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [tfn_pkg::MINLEN_W-1:0] cfg_wdata,
  tfn_tri_if triangle,
  tfn_nrm_if normal,
  output int mismatches,
  output int outstanding
);
  localparam int FRAC = tfn_pkg::NORMAL_FRAC_BITS_DEF;

  logic [tfn_pkg::MINLEN_W-1:0] min_length_shadow;
  tfn_pkg::result_t normals_due[$];

  // Restoring division of a component by the length, truncated toward zero.
  function automatic logic [tfn_pkg::OUT_W-1:0] unit_component(longint num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = (num < 0) ? 64'(-num) : 64'(num);
    quo = 0;
    if (rem >= den) begin
      quo = 1;
      rem = rem - den;
    end
    for (int k = 0; k < FRAC; k++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    if (num < 0) quo = -quo;
    return quo[tfn_pkg::OUT_W-1:0];
  endfunction

  function automatic tfn_pkg::result_t face_normal(tfn_pkg::tri_t t,
                                                   logic [tfn_pkg::MINLEN_W-1:0] min_len);
    longint e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz;
    logic [87:0] mx, my, mz, sum_sq, cand;
    logic [63:0] len;
    tfn_pkg::result_t r;
    e0x = longint'(t.bx) - longint'(t.ax);
    e0y = longint'(t.by) - longint'(t.ay);
    e0z = longint'(t.bz) - longint'(t.az);
    e1x = longint'(t.cx) - longint'(t.ax);
    e1y = longint'(t.cy) - longint'(t.ay);
    e1z = longint'(t.cz) - longint'(t.az);
    nx = e0y * e1z - e0z * e1y;
    ny = e0z * e1x - e0x * e1z;
    nz = e0x * e1y - e0y * e1x;
    mx = (nx < 0) ? 88'(-nx) : 88'(nx);
    my = (ny < 0) ? 88'(-ny) : 88'(ny);
    mz = (nz < 0) ? 88'(-nz) : 88'(nz);
    sum_sq = mx * mx + my * my + mz * mz;
    // Bit-by-bit integer square root over the 43 root bits.
    len = 0;
    for (int b = tfn_pkg::ROOT_W - 1; b >= 0; b--) begin
      cand = 88'(len | (64'd1 << b));
      if (cand * cand <= sum_sq) len = cand[63:0];
    end
    if (len == 0 || len < 64'(min_len)) begin
      r.nx = 0;
      r.ny = tfn_pkg::OUT_W'(1 << FRAC);
      r.nz = 0;
      r.degen = 1'b1;
    end else begin
      r.nx = unit_component(nx, len);
      r.ny = unit_component(ny, len);
      r.nz = unit_component(nz, len);
      r.degen = 1'b0;
    end
    r.idx = t.idx;
    return r;
  endfunction

  assign outstanding = normals_due.size();

  always @(posedge clk) begin
    tfn_pkg::tri_t t;
    tfn_pkg::result_t got, want;
    if (rst) begin
      min_length_shadow <= tfn_pkg::MIN_LENGTH_RESET;
      normals_due.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) min_length_shadow <= cfg_wdata;
      if (triangle.valid && triangle.ready) begin
        t.ax = triangle.vert_a_x;
        t.ay = triangle.vert_a_y;
        t.az = triangle.vert_a_z;
        t.bx = triangle.vert_b_x;
        t.by = triangle.vert_b_y;
        t.bz = triangle.vert_b_z;
        t.cx = triangle.vert_c_x;
        t.cy = triangle.vert_c_y;
        t.cz = triangle.vert_c_z;
        t.idx.a = triangle.vert_a_index;
        t.idx.b = triangle.vert_b_index;
        t.idx.c = triangle.vert_c_index;
        normals_due.insert(normals_due.size(), face_normal(t, min_length_shadow));
      end
      if (normal.valid && normal.ready) begin
        got.nx = normal.normal_x;
        got.ny = normal.normal_y;
        got.nz = normal.normal_z;
        got.degen = normal.degenerate;
        got.idx.a = normal.out_vert_a_index;
        got.idx.b = normal.out_vert_b_index;
        got.idx.c = normal.out_vert_c_index;
        if (normals_due.size() == 0) begin
          $display("%0t: unexpected normal %p", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          want = normals_due.pop_front();
          if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
              got.degen !== want.degen || got.idx !== want.idx) begin
            $display("%0t: normal mismatch expected %p actual %p", $time, want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/tb_triangle_face_normal_unit.sv
// Top of the triangle face normal testbench: clock, reset, triangle stimulus,
// output back-pressure, min_length phases and the verdict. Depends on tfn_pkg,
// tfn_ifs, the unit itself and tfn_normal_checker.
`timescale 1ns / 1ps

module tb_triangle_face_normal_unit;
  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int SETTLE = 100;       // comfortably beyond the pipeline latency
  localparam int LO = -524288;
  localparam int HI = 524287;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tfn_pkg::MINLEN_W-1:0] cfg_wdata;
  int mismatches;
  int outstanding;
  // While jitter is set, both sides insert random idle bursts.
  logic jitter;
  int quiet_cycles;

  tfn_tri_if triangle ();
  tfn_nrm_if normal ();

  triangle_face_normal_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .triangle(triangle),
    .normal(normal)
  );

  tfn_normal_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .triangle(triangle),
    .normal(normal),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The output side stalls in bursts while jitter is on, and is always ready otherwise.
  initial begin
    normal.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (jitter && $urandom_range(0, 3) == 0) begin
        normal.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      normal.ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // The watchdog counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (triangle.valid && triangle.ready) || (normal.valid && normal.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL triangle_face_normal_unit");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_triangle(tfn_pkg::tri_t t);
    if (jitter && $urandom_range(0, 4) == 0) begin
      triangle.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    triangle.vert_a_x = t.ax;
    triangle.vert_a_y = t.ay;
    triangle.vert_a_z = t.az;
    triangle.vert_b_x = t.bx;
    triangle.vert_b_y = t.by;
    triangle.vert_b_z = t.bz;
    triangle.vert_c_x = t.cx;
    triangle.vert_c_y = t.cy;
    triangle.vert_c_z = t.cz;
    triangle.vert_a_index = t.idx.a;
    triangle.vert_b_index = t.idx.b;
    triangle.vert_c_index = t.idx.c;
    triangle.valid = 1'b1;
    do @(posedge clk); while (!triangle.ready);
    @(negedge clk);
  endtask

  // Waits for every expected normal, lets the pipeline empty, then writes min_length.
  task automatic set_min_length(logic [tfn_pkg::MINLEN_W-1:0] value);
    triangle.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [tfn_pkg::COORD_W-1:0] any_coord();
    return tfn_pkg::COORD_W'($urandom);
  endfunction

  // Random triangles of several kinds: full range, small, collinear, coincident.
  function automatic tfn_pkg::tri_t random_triangle();
    tfn_pkg::tri_t t;
    int kind;
    int s;
    logic signed [tfn_pkg::COORD_W-1:0] dx, dy, dz;
    kind = $urandom_range(0, 9);
    t.ax = any_coord();
    t.ay = any_coord();
    t.az = any_coord();
    t.bx = any_coord();
    t.by = any_coord();
    t.bz = any_coord();
    t.cx = any_coord();
    t.cy = any_coord();
    t.cz = any_coord();
    if (kind >= 4 && kind <= 6) begin
      // Small triangle near the first vertex, so the length lands near the thresholds.
      s = 1 << $urandom_range(0, 12);
      t.bx = t.ax + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
      t.by = t.ay + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
      t.bz = t.az + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
      t.cx = t.ax + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
      t.cy = t.ay + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
      t.cz = t.az + tfn_pkg::COORD_W'($urandom_range(0, 2 * s) - s);
    end else if (kind == 7 || kind == 8) begin
      // Collinear: the third vertex continues the first edge.
      dx = tfn_pkg::COORD_W'($urandom_range(0, 2000) - 1000);
      dy = tfn_pkg::COORD_W'($urandom_range(0, 2000) - 1000);
      dz = tfn_pkg::COORD_W'($urandom_range(0, 2000) - 1000);
      s = $urandom_range(0, 5) - 2;
      t.bx = t.ax + dx;
      t.by = t.ay + dy;
      t.bz = t.az + dz;
      t.cx = t.ax + tfn_pkg::COORD_W'(s) * dx;
      t.cy = t.ay + tfn_pkg::COORD_W'(s) * dy;
      t.cz = t.az + tfn_pkg::COORD_W'(s) * dz;
    end else if (kind == 9) begin
      t.bx = t.ax;
      t.by = t.ay;
      t.bz = t.az;
    end
    t.idx.a = $urandom;
    t.idx.b = $urandom;
    t.idx.c = $urandom;
    return t;
  endfunction

  function automatic tfn_pkg::tri_t make_triangle(int ax, int ay, int az, int bx, int by,
                                                  int bz, int cx, int cy, int cz,
                                                  logic [tfn_pkg::IDX_W-1:0] ia);
    tfn_pkg::tri_t t;
    t.ax = tfn_pkg::COORD_W'(ax);
    t.ay = tfn_pkg::COORD_W'(ay);
    t.az = tfn_pkg::COORD_W'(az);
    t.bx = tfn_pkg::COORD_W'(bx);
    t.by = tfn_pkg::COORD_W'(by);
    t.bz = tfn_pkg::COORD_W'(bz);
    t.cx = tfn_pkg::COORD_W'(cx);
    t.cy = tfn_pkg::COORD_W'(cy);
    t.cz = tfn_pkg::COORD_W'(cz);
    t.idx.a = ia;
    t.idx.b = ~ia;
    t.idx.c = ia ^ 32'h5a5a_a5a5;
    return t;
  endfunction

  initial begin
    logic [tfn_pkg::MINLEN_W-1:0] phase_min [5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    jitter = 1'b0;
    triangle.valid = 1'b0;
    {triangle.vert_a_x, triangle.vert_a_y, triangle.vert_a_z} = '0;
    {triangle.vert_b_x, triangle.vert_b_y, triangle.vert_b_z} = '0;
    {triangle.vert_c_x, triangle.vert_c_y, triangle.vert_c_z} = '0;
    {triangle.vert_a_index, triangle.vert_b_index, triangle.vert_c_index} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed triangles at the reset threshold of 1.
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
    send_triangle(make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0, 32'hffff_ffff));
    send_triangle(make_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0, 32'h1));
    send_triangle(make_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0, 32'h8000_0000));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, 32'h7fff_ffff));
    send_triangle(make_triangle(LO, LO, LO, HI, LO, LO, LO, HI, LO, 32'h1234_5678));
    send_triangle(make_triangle(HI, HI, HI, LO, HI, HI, HI, LO, HI, 32'hdead_0001));
    send_triangle(make_triangle(LO, LO, LO, HI, HI, HI, LO, HI, LO, 32'h0f0f_0f0f));
    send_triangle(make_triangle(HI, LO, HI, LO, HI, LO, HI, HI, LO, 32'hf0f0_f0f0));
    send_triangle(make_triangle(10, 20, 30, 20, 40, 60, 30, 60, 90, 32'h2));
    send_triangle(make_triangle(LO, LO, LO, HI, HI, HI, LO, LO, LO, 32'h3));
    send_triangle(make_triangle(HI, HI, HI, HI, HI, HI, HI, HI, HI, 32'h4));
    send_triangle(make_triangle(100, -7, 3, -55, 900, 12, 40, 41, -999, 32'h5));
    send_triangle(make_triangle(0, 0, 0, 3, 0, 0, 0, 1, 1, 32'h6));

    // Each phase writes a new threshold; zero and the largest value are the extremes.
    phase_min[0] = 44'd1;
    phase_min[1] = 44'd0;
    phase_min[2] = 44'hfff_ffff_ffff;
    phase_min[3] = 44'd1 << $urandom_range(8, 40);
    phase_min[4] = 44'd1 << $urandom_range(16, 30);
    for (int p = 0; p < 5; p++) begin
      set_min_length(phase_min[p]);
      // Only the last phase runs with both sides flat out.
      jitter = (p < 4);
      for (int n = 0; n < 265; n++) send_triangle(random_triangle());
    end

    triangle.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS triangle_face_normal_unit");
    end else begin
      $display("FAIL triangle_face_normal_unit");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_ifs.sv
hw/rtl/tfn_cross.sv
hw/rtl/tfn_sqrt.sv
hw/rtl/tfn_div.sv
hw/rtl/triangle_face_normal_unit.sv
verif/tfn_normal_checker.sv
verif/tb_triangle_face_normal_unit.sv
